// ----- hdl/pps_pkg.sv -----
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

  localparam int SLOT_W    = 4;
  localparam int ARRIVAL_W = 16;
  localparam int BURST_W   = 16;
  localparam int PRIO_W    = 7;
  localparam int TIME_W    = 24;
  localparam int COUNT_W   = 5;

  localparam logic [TIME_W-1:0]  TIME_MAX     = 24'hFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 5'd31;
  localparam logic [COUNT_W-1:0] PCOUNT_RESET = 5'd16;

  // Command codes of the input channel.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Request queue between front and back; depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Classified request as handed from front to back.
  typedef struct packed {
    logic                 is_tick;
    logic                 load_ok;
    logic [SLOT_W-1:0]    slot;
    logic [ARRIVAL_W-1:0] arrival;
    logic [BURST_W-1:0]   burst;
    logic [PRIO_W-1:0]    prio;
  } req_t;

endpackage

// ----- hdl/pps_front.sv -----
// Input side: accepts requests, classifies them and queues them for the back end.
module pps_front #(
  parameter int MAX_PROCESSES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic [pps_pkg::SLOT_W-1:0]      in_slot,
  input  logic [pps_pkg::ARRIVAL_W-1:0]   in_arrival_time,
  input  logic [pps_pkg::BURST_W-1:0]     in_burst_length,
  input  logic [pps_pkg::PRIO_W-1:0]      in_priority_level,
  output logic                            req_valid,
  output pps_pkg::req_t                   req_head,
  input  logic                            req_pop
);

  pps_pkg::req_t                    queue_r [pps_pkg::QUEUE_DEPTH];
  logic [pps_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [pps_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [pps_pkg::QCNT_W-1:0]       count_r;
  pps_pkg::req_t                    req_new;
  logic                             push;
  logic                             pop;

  assign in_stall  = (count_r == pps_pkg::QCNT_W'(pps_pkg::QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign req_valid = (count_r != '0);
  assign pop       = req_pop && req_valid;
  assign req_head  = queue_r[rd_ptr_r];

  // Loads to slots beyond the table are flagged here and dropped by the back end.
  always_comb begin
    req_new.is_tick = (in_command == pps_pkg::CMD_TICK);
    req_new.load_ok = (int'(in_slot) < MAX_PROCESSES);
    req_new.slot    = in_slot;
    req_new.arrival = in_arrival_time;
    req_new.burst   = in_burst_length;
    req_new.prio    = in_priority_level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        queue_r[wr_ptr_r] <= req_new;
        wr_ptr_r          <= wr_ptr_r + pps_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + pps_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + pps_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - pps_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// ----- hdl/pps_back.sv -----
// Execution side: process table, sequential priority scan, time keeping and result register.
module pps_back #(
  parameter int MAX_PROCESSES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pps_pkg::COUNT_W-1:0]     cfg_process_count,
  input  logic                            req_valid,
  input  pps_pkg::req_t                   req_head,
  output logic                            req_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_idle,
  output logic [pps_pkg::SLOT_W-1:0]      out_running_slot,
  output logic                            out_finished,
  output logic [pps_pkg::TIME_W-1:0]      out_completion_time,
  output logic [pps_pkg::TIME_W-1:0]      out_turnaround,
  output logic [pps_pkg::TIME_W-1:0]      out_waiting,
  output logic                            out_all_done
);

  localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int NUM_W = $clog2(MAX_PROCESSES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHARGE,
    ST_REPORT
  } state_t;

  state_t                            state_r;
  logic [pps_pkg::COUNT_W-1:0]       pcount_r;
  logic [pps_pkg::TIME_W-1:0]        time_r;
  logic [pps_pkg::COUNT_W-1:0]       done_cnt_r;

  logic [pps_pkg::ARRIVAL_W-1:0]     arrival_r [MAX_PROCESSES];
  logic [pps_pkg::BURST_W-1:0]       burst_r   [MAX_PROCESSES];
  logic [pps_pkg::BURST_W-1:0]       remain_r  [MAX_PROCESSES];
  logic [pps_pkg::PRIO_W-1:0]        prio_r    [MAX_PROCESSES];
  logic [MAX_PROCESSES-1:0]          live_r;

  logic [IDX_W-1:0]                  idx_r;
  logic                              found_r;
  logic [IDX_W-1:0]                  best_idx_r;
  logic [pps_pkg::PRIO_W-1:0]        best_prio_r;
  logic [pps_pkg::ARRIVAL_W-1:0]     best_arrival_r;
  logic [pps_pkg::BURST_W-1:0]       best_burst_r;
  logic [pps_pkg::BURST_W-1:0]       best_remain_r;
  logic                              done_r;
  logic [pps_pkg::TIME_W-1:0]        turn_r;

  logic                              out_valid_r;
  logic                              out_idle_r;
  logic [pps_pkg::SLOT_W-1:0]        out_slot_r;
  logic                              out_finished_r;
  logic [pps_pkg::TIME_W-1:0]        out_time_r;
  logic [pps_pkg::TIME_W-1:0]        out_turn_r;
  logic [pps_pkg::TIME_W-1:0]        out_wait_r;
  logic                              out_all_done_r;

  logic [NUM_W-1:0]                  active_num;
  logic                              scan_last;
  logic                              eligible;
  logic                              better;
  logic [IDX_W-1:0]                  load_idx;
  logic [pps_pkg::TIME_W-1:0]        time_nxt;
  logic [pps_pkg::TIME_W-1:0]        burst_ext;
  logic [pps_pkg::TIME_W-1:0]        wait_val;
  logic                              out_free;

  // Only slots below min(process_count, table size) take part.
  always_comb begin
    if (int'(pcount_r) < MAX_PROCESSES) begin
      active_num = NUM_W'(pcount_r);
    end else begin
      active_num = NUM_W'(MAX_PROCESSES);
    end
  end

  assign scan_last = (NUM_W'(idx_r) + NUM_W'(1) == active_num);
  assign eligible  = live_r[idx_r] &&
                     (pps_pkg::TIME_W'(arrival_r[idx_r]) <= time_r);
  assign better    = !found_r || (prio_r[idx_r] < best_prio_r);
  assign load_idx  = IDX_W'(req_head.slot);
  assign time_nxt  = (time_r < pps_pkg::TIME_MAX) ? time_r + pps_pkg::TIME_W'(1) : time_r;
  assign burst_ext = pps_pkg::TIME_W'(best_burst_r);
  // Waiting clamps at zero once time has saturated.
  assign wait_val  = (turn_r > burst_ext) ? turn_r - burst_ext : '0;
  assign out_free  = !out_valid_r || !out_stall;
  assign req_pop   = (state_r == ST_IDLE) && req_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pcount_r    <= pps_pkg::PCOUNT_RESET;
      time_r      <= '0;
      done_cnt_r  <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        pcount_r <= cfg_process_count;
      end
      // Drop an accepted result unless a new one replaces it this cycle.
      if (out_valid_r && !out_stall && (state_r != ST_REPORT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (req_valid) begin
            if (req_head.is_tick) begin
              idx_r   <= '0;
              found_r <= 1'b0;
              state_r <= (active_num == '0) ? ST_CHARGE : ST_SCAN;
            end else if (req_head.load_ok) begin
              arrival_r[load_idx] <= req_head.arrival;
              burst_r[load_idx]   <= req_head.burst;
              remain_r[load_idx]  <= req_head.burst;
              prio_r[load_idx]    <= req_head.prio;
              live_r[load_idx]    <= (req_head.burst != '0);
            end
          end
        end
        ST_SCAN: begin
          // Strict compare keeps the lowest slot on equal priority.
          if (eligible && better) begin
            found_r        <= 1'b1;
            best_idx_r     <= idx_r;
            best_prio_r    <= prio_r[idx_r];
            best_arrival_r <= arrival_r[idx_r];
            best_burst_r   <= burst_r[idx_r];
            best_remain_r  <= remain_r[idx_r];
          end
          idx_r <= idx_r + IDX_W'(1);
          if (scan_last) begin
            state_r <= ST_CHARGE;
          end
        end
        ST_CHARGE: begin
          time_r <= time_nxt;
          done_r <= 1'b0;
          turn_r <= '0;
          if (found_r) begin
            remain_r[best_idx_r] <= best_remain_r - pps_pkg::BURST_W'(1);
            if (best_remain_r == pps_pkg::BURST_W'(1)) begin
              live_r[best_idx_r] <= 1'b0;
              done_r             <= 1'b1;
              turn_r             <= time_nxt - pps_pkg::TIME_W'(best_arrival_r);
              if (done_cnt_r < pps_pkg::COUNT_MAX) begin
                done_cnt_r <= done_cnt_r + pps_pkg::COUNT_W'(1);
              end
            end
          end
          state_r <= ST_REPORT;
        end
        ST_REPORT: begin
          // Hold until the result register is free.
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_idle_r     <= !found_r;
            out_slot_r     <= found_r ? pps_pkg::SLOT_W'(best_idx_r) : '0;
            out_finished_r <= done_r;
            out_time_r     <= time_r;
            out_turn_r     <= turn_r;
            out_wait_r     <= done_r ? wait_val : '0;
            out_all_done_r <= (done_cnt_r >= pcount_r);
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_idle            = out_idle_r;
  assign out_running_slot    = out_slot_r;
  assign out_finished        = out_finished_r;
  assign out_completion_time = out_time_r;
  assign out_turnaround      = out_turn_r;
  assign out_waiting         = out_wait_r;
  assign out_all_done        = out_all_done_r;

endmodule

// ----- hdl/preemptive_priority_scheduler.sv -----
// Preemptive priority scheduler: top level joining the request front end and the execution back end.
//
// Usage: the in_ channel carries requests. in_command selects a load, which writes
// one process slot (arrival, burst, priority) and gives no result, or a tick, which
// advances time by one, charges one unit of work to the eligible slot of lowest
// priority value (lowest slot on a tie) and gives exactly one result on out_.
// cfg_we with cfg_process_count sets how many slots take part; write it while idle.
// Requests enter a two-deep queue, so in_stall rises only when it is full.
// A load is handled by the back end in its dispatch state alone. A tick passes
// through dispatch, a priority scan over the process table that visits slots 0 to
// N-1 in turn, N being min(process_count, MAX_PROCESSES), a charge step and a
// report step that registers the result; the back end takes no new request until then.
// While out_stall is high a valid result stays in the result register and the back end
// waits with the next result; the queue keeps taking requests until full.
// Reset (rst_n low at a clock edge) empties the queue, clears time, the completion
// count and all remaining work, and sets process_count to 16.
module preemptive_priority_scheduler #(
  parameter int MAX_PROCESSES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pps_pkg::COUNT_W-1:0]     cfg_process_count,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic [pps_pkg::SLOT_W-1:0]      in_slot,
  input  logic [pps_pkg::ARRIVAL_W-1:0]   in_arrival_time,
  input  logic [pps_pkg::BURST_W-1:0]     in_burst_length,
  input  logic [pps_pkg::PRIO_W-1:0]      in_priority_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_idle,
  output logic [pps_pkg::SLOT_W-1:0]      out_running_slot,
  output logic                            out_finished,
  output logic [pps_pkg::TIME_W-1:0]      out_completion_time,
  output logic [pps_pkg::TIME_W-1:0]      out_turnaround,
  output logic [pps_pkg::TIME_W-1:0]      out_waiting,
  output logic                            out_all_done
);

  logic          req_valid;
  pps_pkg::req_t req_head;
  logic          req_pop;

  pps_front #(
    .MAX_PROCESSES(MAX_PROCESSES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_slot          (in_slot),
    .in_arrival_time  (in_arrival_time),
    .in_burst_length  (in_burst_length),
    .in_priority_level(in_priority_level),
    .req_valid        (req_valid),
    .req_head         (req_head),
    .req_pop          (req_pop)
  );

  pps_back #(
    .MAX_PROCESSES(MAX_PROCESSES)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_process_count  (cfg_process_count),
    .req_valid          (req_valid),
    .req_head           (req_head),
    .req_pop            (req_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_idle           (out_idle),
    .out_running_slot   (out_running_slot),
    .out_finished       (out_finished),
    .out_completion_time(out_completion_time),
    .out_turnaround     (out_turnaround),
    .out_waiting        (out_waiting),
    .out_all_done       (out_all_done)
  );

endmodule
